// File: hdl/rans_nibble_decoder_unit_macros.svh
// Assertion macros for the rANS nibble decoder RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef RANS_NIBBLE_DECODER_UNIT_MACROS_SVH
`define RANS_NIBBLE_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define RND_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RND_ASSERT(lbl, clk, rst_n, prop)
`define RND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/rnd_pkg.sv
// Shared types, constants and helper functions of the rANS nibble decoder.
// No dependencies; used by the interfaces and all modules.
package rnd_pkg;

  localparam int unsigned SymCount  = 16;
  localparam int unsigned HalfCount = 8;
  localparam int unsigned FreqW     = 8;
  localparam int unsigned StateW    = 16;
  localparam int unsigned SymW      = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] CFG_FREQ_LO = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FREQ_HI = 2'd1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [SymW-1:0] SYM_BIAS = 4'd8;

  typedef struct packed {
    logic              cmd;
    logic [StateW-1:0] load_value;
    logic [FreqW-1:0]  next_byte;
    logic              byte_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [SymW-1:0] symbol;
    logic                   byte_used;
    logic [StateW-1:0]      coder_state;
  } out_item_t;

  typedef struct packed {
    logic [SymCount-1:0][FreqW-1:0] freq;
    logic [SymCount-1:0][FreqW-1:0] cum;
  } freq_tbl_t;

  // Exclusive running sums of eight frequencies; entry HalfCount is the total.
  function automatic logic [HalfCount:0][FreqW-1:0] prefix_sums(
    input logic [CfgDataW-1:0] word
  );
    logic [HalfCount:0][FreqW-1:0] acc;
    acc[0] = '0;
    for (int i = 0; i < HalfCount; i++) begin
      acc[i+1] = acc[i] + word[i*FreqW +: FreqW];
    end
    return acc;
  endfunction

endpackage

// File: hdl/rnd_in_if.sv
// Input item channel of the rANS nibble decoder.
// Depends on rnd_pkg for field widths.
interface rnd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [rnd_pkg::StateW-1:0]     load_value;
  logic [rnd_pkg::FreqW-1:0]      next_byte;
  logic                           byte_valid;

  modport source (output valid, cmd, load_value, next_byte, byte_valid, input ready);
  modport sink   (input valid, cmd, load_value, next_byte, byte_valid, output ready);
endinterface

// File: hdl/rnd_out_if.sv
// Result item channel of the rANS nibble decoder.
// Depends on rnd_pkg for field widths.
interface rnd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rnd_pkg::SymW-1:0]   symbol;
  logic                              byte_used;
  logic [rnd_pkg::StateW-1:0]        coder_state;

  modport source (output valid, symbol, byte_used, coder_state, input ready);
  modport sink   (input valid, symbol, byte_used, coder_state, output ready);
endinterface

// File: hdl/rnd_cfg_if.sv
// Configuration write channel of the rANS nibble decoder.
// Depends on rnd_pkg for index and data widths.
interface rnd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rnd_pkg::CfgIdxW-1:0]   index;
  logic [rnd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/rnd_freq_table.sv
// Frequency registers and cumulative start table of the rANS nibble decoder.
// Depends on rnd_pkg; running sums of each half are registered on write.
module rnd_freq_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [rnd_pkg::CfgIdxW-1:0]   wr_index_i,
  input  logic [rnd_pkg::CfgDataW-1:0]  wr_data_i,
  output rnd_pkg::freq_tbl_t            tbl_o
);
  import rnd_pkg::*;

  logic [CfgDataW-1:0]               freq_lo_q, freq_hi_q;
  logic [HalfCount-1:0][FreqW-1:0]   lo_cum_q, hi_rel_q;
  logic [FreqW-1:0]                  lo_total_q;
  logic [HalfCount:0][FreqW-1:0]     sums_d;

  assign sums_d = prefix_sums(wr_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_lo_q  <= '0;
      freq_hi_q  <= '0;
      lo_cum_q   <= '0;
      hi_rel_q   <= '0;
      lo_total_q <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CFG_FREQ_LO: begin
          freq_lo_q  <= wr_data_i;
          lo_cum_q   <= sums_d[HalfCount-1:0];
          lo_total_q <= sums_d[HalfCount];
        end
        CFG_FREQ_HI: begin
          freq_hi_q <= wr_data_i;
          hi_rel_q  <= sums_d[HalfCount-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int s = 0; s < HalfCount; s++) begin
      tbl_o.freq[s]           = freq_lo_q[s*FreqW +: FreqW];
      tbl_o.freq[s+HalfCount] = freq_hi_q[s*FreqW +: FreqW];
      tbl_o.cum[s]            = lo_cum_q[s];
      tbl_o.cum[s+HalfCount]  = lo_total_q + hi_rel_q[s];
    end
  end
endmodule

// File: hdl/rnd_decode_core.sv
// Decode datapath: symbol search, state update, renormalization.
// Depends on rnd_pkg; purely combinational.
module rnd_decode_core (
  input  logic [rnd_pkg::StateW-1:0]  state_i,
  input  rnd_pkg::in_item_t           item_i,
  input  rnd_pkg::freq_tbl_t          tbl_i,
  output rnd_pkg::out_item_t          result_o
);
  import rnd_pkg::*;

  logic [FreqW-1:0]  slot;
  logic [SymW-1:0]   sel;
  logic [FreqW-1:0]  sel_freq, sel_cum;
  logic [StateW-1:0] prod, ns;
  logic              renorm;

  always_comb begin
    slot     = state_i[FreqW-1:0];
    sel      = '0;
    sel_freq = tbl_i.freq[0];
    sel_cum  = '0;
    for (int s = 0; s < SymCount; s++) begin
      if (tbl_i.freq[s] != '0 && tbl_i.cum[s] <= slot) begin
        sel      = SymW'(s);
        sel_freq = tbl_i.freq[s];
        sel_cum  = tbl_i.cum[s];
      end
    end
    prod   = state_i[StateW-1:FreqW] * sel_freq;
    ns     = prod + {{(StateW-FreqW){1'b0}}, slot} - {{(StateW-FreqW){1'b0}}, sel_cum};
    renorm = (ns[StateW-1:FreqW] == '0) && item_i.byte_valid;

    if (item_i.cmd == CMD_LOAD) begin
      result_o.symbol      = '0;
      result_o.byte_used   = 1'b0;
      result_o.coder_state = item_i.load_value;
    end else begin
      result_o.symbol      = sel - SYM_BIAS;
      result_o.byte_used   = renorm;
      result_o.coder_state = renorm ? {ns[FreqW-1:0], item_i.next_byte} : ns;
    end
  end
endmodule

// File: hdl/rans_nibble_decoder_unit.sv
// rANS nibble decoder top level: input register, decode datapath, result register.
// Depends on rnd_pkg, the channel interfaces, rnd_freq_table, rnd_decode_core and
// the assertion macro header.
//
// Takes one transaction per cycle, with no bubbles as long as results are taken.
// Each input is held in the input register, and its result in the result register,
// from which it is offered. While results are held off, two transactions wait
// in the input and result registers before the input stalls. The rate is set by the
// loop through the coder state register: one priority search over sixteen
// cumulative starts, one 8x8 multiply and the renormalization shift each cycle.
// Configuration writes are taken every cycle and apply to the next item.
`include "rans_nibble_decoder_unit_macros.svh"

module rans_nibble_decoder_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  rnd_in_if.sink    in_i,
  rnd_out_if.source out_o,
  rnd_cfg_if.sink   cfg_i
);
  import rnd_pkg::*;

  in_item_t          item_q;
  logic              item_valid_q;
  out_item_t         res_q, res_d;
  logic              res_valid_q;
  logic [StateW-1:0] state_q;
  freq_tbl_t         tbl;
  logic              advance, in_accept;

  assign cfg_i.ready = 1'b1;

  rnd_freq_table u_freq_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .tbl_o      (tbl)
  );

  rnd_decode_core u_decode_core (
    .state_i  (state_q),
    .item_i   (item_q),
    .tbl_i    (tbl),
    .result_o (res_d)
  );

  assign advance    = !res_valid_q || out_o.ready;
  assign in_i.ready = !item_valid_q || advance;
  assign in_accept  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      state_q      <= '0;
    end else begin
      if (in_accept) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= item_valid_q;
        if (item_valid_q) begin
          state_q <= res_d.coder_state;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.cmd        <= in_i.cmd;
      item_q.load_value <= in_i.load_value;
      item_q.next_byte  <= in_i.next_byte;
      item_q.byte_valid <= in_i.byte_valid;
    end
    if (advance && item_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.symbol      = res_q.symbol;
  assign out_o.byte_used   = res_q.byte_used;
  assign out_o.coder_state = res_q.coder_state;

  `RND_ASSERT_NEXT(a_stall_holds_state, clk_i, rst_ni, res_valid_q && !out_o.ready, $stable(state_q))
  `RND_ASSERT_NEXT(a_result_matches_state, clk_i, rst_ni, advance && item_valid_q, res_valid_q && res_q.coder_state == state_q)
  `RND_ASSERT(a_load_clears_flags, clk_i, rst_ni, !(item_valid_q && item_q.cmd == CMD_LOAD) || (res_d.symbol == '0 && !res_d.byte_used))
endmodule

// File: verif/rans_nibble_decoder_unit_tb.sv
// Self-checking testbench for rans_nibble_decoder_unit: frequency tables, state loads and
// symbol decodes checked against a cycle-free prediction kept in a scoreboard class.
// Depends on rnd_pkg, the rnd_in_if/rnd_out_if/rnd_cfg_if channels and the DUT.
module rans_nibble_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rnd_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned MaxPrints  = 40;

  class symbol_scoreboard;
    logic [FreqW-1:0]  freq_tab [SymCount];
    logic [StateW-1:0] coder;
    out_item_t         expected_syms [$];
    int unsigned       errors;

    function new();
      foreach (freq_tab[i]) freq_tab[i] = '0;
      coder  = '0;
      errors = 0;
    endfunction

    function void set_freq(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] word);
      int unsigned base;
      if (idx == CFG_FREQ_LO) base = 0;
      else if (idx == CFG_FREQ_HI) base = HalfCount;
      else return;
      for (int i = 0; i < HalfCount; i++) freq_tab[base + i] = word[i*FreqW +: FreqW];
    endfunction

    function int unsigned pending();
      return expected_syms.size();
    endfunction

    function out_item_t decode_predict(in_item_t it);
      out_item_t         r;
      logic [FreqW-1:0]  slot;
      logic [FreqW-1:0]  run;
      logic [FreqW-1:0]  pick_f;
      logic [FreqW-1:0]  pick_c;
      logic [SymW-1:0]   pick;
      logic [StateW-1:0] nxt;
      r = '0;
      if (it.cmd == CMD_LOAD) begin
        coder = it.load_value;
        r.coder_state = coder;
        return r;
      end
      slot   = coder[FreqW-1:0];
      run    = '0;
      pick   = '0;
      pick_f = freq_tab[0];
      pick_c = '0;
      for (int s = 0; s < SymCount; s++) begin
        if (freq_tab[s] != '0 && run <= slot) begin
          pick   = SymW'(s);
          pick_f = freq_tab[s];
          pick_c = run;
        end
        run = run + freq_tab[s];
      end
      nxt = StateW'(32'(coder[StateW-1:FreqW]) * 32'(pick_f) + 32'(slot) - 32'(pick_c));
      if (nxt < (StateW'(1) << FreqW) && it.byte_valid) begin
        nxt = {nxt[FreqW-1:0], it.next_byte};
        r.byte_used = 1'b1;
      end
      coder = nxt;
      r.symbol = pick - SYM_BIAS;
      r.coder_state = nxt;
      return r;
    endfunction

    function void note_input(in_item_t it);
      expected_syms.push_back(decode_predict(it));
    endfunction

    task report_mismatch(string what, int want, int got);
      if (errors < MaxPrints) $display("mismatch %s: expected %0d got %0d", what, want, got);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_syms.size() == 0) begin
        report_mismatch("unexpected transaction, coder_state", -1, got.coder_state);
        return;
      end
      want = expected_syms.pop_front();
      if (got.symbol !== want.symbol) report_mismatch("symbol", want.symbol, got.symbol);
      if (got.byte_used !== want.byte_used)
        report_mismatch("byte_used", want.byte_used, got.byte_used);
      if (got.coder_state !== want.coder_state)
        report_mismatch("coder_state", want.coder_state, got.coder_state);
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   src_idle = 1'b0;
  bit   sink_idle = 1'b0;
  bit   hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  symbol_scoreboard sb;

  rnd_in_if  in_ch ();
  rnd_out_if out_ch ();
  rnd_cfg_if cfg_ch ();

  rans_nibble_decoder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(bit idle_on);
    if (!idle_on || $urandom_range(0, 1) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic void make_freqs(output logic [CfgDataW-1:0] lo,
                                     output logic [CfgDataW-1:0] hi);
    logic [FreqW-1:0] f [SymCount];
    int unsigned a;
    int unsigned s;
    int unsigned rem;
    int unsigned add;
    foreach (f[i]) f[i] = '0;
    a = $urandom_range(0, SymCount - 1);
    f[a] = 8'd1;
    f[(a + 1 + $urandom_range(0, SymCount - 2)) % SymCount] = 8'd1;
    repeat ($urandom_range(0, SymCount)) f[$urandom_range(0, SymCount - 1)] = 8'd1;
    rem = 256;
    foreach (f[i]) rem -= f[i];
    while (rem > 0) begin
      s = $urandom_range(0, SymCount - 1);
      if (f[s] != '0 && f[s] != 8'hFF) begin
        add = $urandom_range(1, 40);
        if (add > rem) add = rem;
        if (add > 255 - f[s]) add = 255 - f[s];
        f[s] += FreqW'(add);
        rem -= add;
      end
    end
    for (int i = 0; i < HalfCount; i++) begin
      lo[i*FreqW +: FreqW] = f[i];
      hi[i*FreqW +: FreqW] = f[HalfCount + i];
    end
  endfunction

  task automatic send_item(logic cmd, logic [StateW-1:0] value, logic [FreqW-1:0] nb,
                           logic bv);
    in_item_t    it;
    int unsigned gap;
    it = '{cmd: cmd, load_value: value, next_byte: nb, byte_valid: bv};
    gap = pick_gap(src_idle);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= it.cmd;
    in_ch.load_value <= it.load_value;
    in_ch.next_byte  <= it.next_byte;
    in_ch.byte_valid <= it.byte_valid;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic in_idle();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_freqs(logic [CfgDataW-1:0] lo, logic [CfgDataW-1:0] hi);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_FREQ_LO;
    cfg_ch.data  <= lo;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.set_freq(CFG_FREQ_LO, lo);
    cfg_ch.index <= CFG_FREQ_HI;
    cfg_ch.data  <= hi;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.set_freq(CFG_FREQ_HI, hi);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_stream(int unsigned n);
    int unsigned sent;
    int unsigned burst;
    logic [StateW-1:0] start;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), StateW'($urandom()), FreqW'($urandom()),
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        start = ($urandom_range(0, 3) == 0) ? StateW'($urandom())
                                            : StateW'($urandom_range(256, 65535));
        send_item(CMD_LOAD, start, FreqW'($urandom()), 1'($urandom_range(0, 1)));
        sent++;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && sent < n; k++) begin
          send_item(CMD_DECODE, StateW'($urandom()), FreqW'($urandom()),
                    1'($urandom_range(0, 15) != 0));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        gap = pick_gap(sink_idle);
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.symbol      = out_ch.symbol;
      got.byte_used   = out_ch.byte_used;
      got.coder_state = out_ch.coder_state;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("rans_nibble_decoder_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    sb = new();
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_LOAD;
    in_ch.load_value <= '0;
    in_ch.next_byte  <= '0;
    in_ch.byte_valid <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_FREQ_LO;
    cfg_ch.data      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all frequencies zero: no symbol qualifies, symbol 0 with zero freq and start
    send_item(CMD_LOAD, 16'hFFFF, 8'h00, 1'b0);
    send_item(CMD_DECODE, 16'h0000, 8'hAB, 1'b1);
    send_item(CMD_LOAD, 16'h0000, 8'hFF, 1'b1);
    send_item(CMD_DECODE, 16'hFFFF, 8'hFF, 1'b0);
    in_idle();
    wait_drained();

    // zero runs and cumulative starts that wrap past 255
    write_freqs(64'h0020_0000_3000_0010, 64'h4000_3000_2000_1060);
    send_item(CMD_LOAD, 16'h0100, 8'h00, 1'b0);
    send_item(CMD_DECODE, 16'h0000, 8'hFF, 1'b1);
    send_item(CMD_LOAD, 16'hFFFF, 8'h00, 1'b0);
    send_item(CMD_DECODE, 16'h0000, 8'h00, 1'b0);
    send_item(CMD_LOAD, 16'h12FF, 8'h00, 1'b0);
    send_item(CMD_DECODE, 16'h0000, 8'h00, 1'b1);
    send_item(CMD_LOAD, 16'h0080, 8'h00, 1'b0);
    send_item(CMD_DECODE, 16'h0000, 8'h5A, 1'b1);
    send_item(CMD_DECODE, 16'h0000, 8'hA5, 1'b1);
    send_item(CMD_DECODE, 16'h0000, 8'h3C, 1'b0);
    in_idle();
    wait_drained();

    // every frequency at its maximum: overflow and negative differences wrap
    write_freqs('1, '1);
    send_item(CMD_LOAD, 16'hFFFF, 8'h00, 1'b0);
    send_item(CMD_DECODE, 16'h0000, 8'h5A, 1'b1);
    send_item(CMD_LOAD, 16'h00FE, 8'h00, 1'b0);
    send_item(CMD_DECODE, 16'h0000, 8'hFF, 1'b0);
    send_item(CMD_DECODE, 16'h0000, 8'h81, 1'b1);
    send_item(CMD_DECODE, 16'hFFFF, 8'h7E, 1'b1);

    for (int p = 0; p < 6; p++) begin
      in_idle();
      wait_drained();
      case (p)
        0: begin
          lo = '0;
          hi = '0;
        end
        3: begin
          lo = {$urandom(), $urandom()};
          hi = {$urandom(), $urandom()};
        end
        5: begin
          lo = '1;
          hi = '1;
        end
        default: make_freqs(lo, hi);
      endcase
      write_freqs(lo, hi);
      src_idle  = (p == 2 || p == 4 || p == 5);
      sink_idle = (p == 1 || p == 2 || p == 4);
      if (p == 1) hold_req = 1'b1;
      if (p == 2) begin
        run_stream(50);
        in_idle();
        wait_drained();
        run_stream(50);
      end else begin
        run_stream(100);
      end
    end

    in_idle();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("results missing", sb.pending(), 0);
    if (sb.errors == 0) begin
      $display("rans_nibble_decoder_unit_tb OK");
    end else begin
      $display("rans_nibble_decoder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/rnd_pkg.sv
hdl/rnd_in_if.sv
hdl/rnd_out_if.sv
hdl/rnd_cfg_if.sv
hdl/rnd_freq_table.sv
hdl/rnd_decode_core.sv
hdl/rans_nibble_decoder_unit.sv
verif/rans_nibble_decoder_unit_tb.sv
